@@ src/scc_pkg.sv @@
`default_nettype none
package scc_pkg;

	localparam int MAX_NODES_DEF = 1024;
	localparam int MAX_EDGES_DEF = 4096;

	typedef struct packed {
		logic        cmd;
		logic [10:0] src_node;
		logic [10:0] dst_node;
	} in_t;

	typedef struct packed {
		logic [10:0] longest_chain;
		logic        dropped_edges;
	} out_t;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef enum logic [1:0] {
		C_WHITE = 2'd0,
		C_GREY  = 2'd1,
		C_BLACK = 2'd2
	} color_t;

	typedef enum logic [20:0] {
		ST_CLR     = 21'h000001,
		ST_IDLE    = 21'h000002,
		ST_EDGE    = 21'h000004,
		ST_F_ROOT  = 21'h000008,
		ST_F_ROOT2 = 21'h000010,
		ST_F_TOP   = 21'h000020,
		ST_F_TOP2  = 21'h000040,
		ST_F_VIS   = 21'h000080,
		ST_F_EDGE  = 21'h000100,
		ST_F_EDGE2 = 21'h000200,
		ST_R_CLR   = 21'h000400,
		ST_R_ROOT  = 21'h000800,
		ST_R_ROOT2 = 21'h001000,
		ST_R_ROOT3 = 21'h002000,
		ST_R_TOP   = 21'h004000,
		ST_R_TOP2  = 21'h008000,
		ST_R_VIS   = 21'h010000,
		ST_R_EDGE  = 21'h020000,
		ST_R_EDGE2 = 21'h040000,
		ST_R_EDGE3 = 21'h080000,
		ST_DONE    = 21'h100000
	} step_t;

	typedef struct packed {
		step_t step;
		logic  accept;
	} cmd_t;

	typedef struct packed {
		logic is_start;
		logic edge_bad;
		logic root_over;
		logic sp_zero;
		logic col_white;
		logic col_grey;
		logic list_ne;
		logic at_tail;
		logic k_zero;
		logic sweep_last;
	} sts_t;

endpackage
`default_nettype wire

@@ src/scc_longest_chain_core.sv @@
`default_nettype none
// For an edge item (cmd add), the accept cycle writes the edge and ST_EDGE then
// appends it to the forward and reverse lists; a bad edge only sets the drop
// flag and leaves the block idle. A start item walks the graph on one set of
// simple dual-port memories, with a color sweep between the forward and reverse
// passes, so its time grows with nodes plus edges. The result shows on result
// for the one cycle result_valid is high and must be taken then. After each
// result, and after reset, a clear sweep runs with busy high; config writes are
// taken at any time.
module scc_longest_chain_core #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire scc_pkg::in_t item,
	output scc_pkg::out_t     result,
	output logic              result_valid,
	input  wire logic         cfg_we,
	input  wire logic [10:0]  cfg_data
);
	scc_pkg::cmd_t cmd;
	scc_pkg::sts_t sts;

	scc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy));

	scc_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .item(item), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .result(result), .result_valid(result_valid));
endmodule
`default_nettype wire

@@ src/scc_ram.sv @@
`default_nettype none
module scc_ram #(
	parameter int W = 8,
	parameter int D = 16,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

@@ src/scc_ctrl.sv @@
`default_nettype none
module scc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire scc_pkg::sts_t sts,
	output scc_pkg::cmd_t      cmd,
	output logic               busy
);
	scc_pkg::step_t state_q, state_d;

	assign busy       = (state_q != scc_pkg::ST_IDLE);
	assign cmd.step   = state_q;
	assign cmd.accept = start && !busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			scc_pkg::ST_CLR:     if (sts.sweep_last) state_d = scc_pkg::ST_IDLE;
			scc_pkg::ST_IDLE: begin
				if (start) begin
					if (sts.is_start) state_d = scc_pkg::ST_F_ROOT;
					else if (!sts.edge_bad) state_d = scc_pkg::ST_EDGE;
				end
			end
			scc_pkg::ST_EDGE:    state_d = scc_pkg::ST_IDLE;
			scc_pkg::ST_F_ROOT:  state_d = sts.root_over ? scc_pkg::ST_R_CLR : scc_pkg::ST_F_ROOT2;
			scc_pkg::ST_F_ROOT2: state_d = sts.col_white ? scc_pkg::ST_F_TOP : scc_pkg::ST_F_ROOT;
			scc_pkg::ST_F_TOP:   state_d = sts.sp_zero ? scc_pkg::ST_F_ROOT : scc_pkg::ST_F_TOP2;
			scc_pkg::ST_F_TOP2:  state_d = scc_pkg::ST_F_VIS;
			scc_pkg::ST_F_VIS: begin
				if (sts.col_white && sts.list_ne) state_d = scc_pkg::ST_F_EDGE;
				else state_d = scc_pkg::ST_F_TOP;
			end
			scc_pkg::ST_F_EDGE:  state_d = scc_pkg::ST_F_EDGE2;
			scc_pkg::ST_F_EDGE2: state_d = sts.at_tail ? scc_pkg::ST_F_TOP : scc_pkg::ST_F_EDGE;
			scc_pkg::ST_R_CLR:   if (sts.sweep_last) state_d = scc_pkg::ST_R_ROOT;
			scc_pkg::ST_R_ROOT:  state_d = sts.k_zero ? scc_pkg::ST_DONE : scc_pkg::ST_R_ROOT2;
			scc_pkg::ST_R_ROOT2: state_d = scc_pkg::ST_R_ROOT3;
			scc_pkg::ST_R_ROOT3: state_d = sts.col_white ? scc_pkg::ST_R_TOP : scc_pkg::ST_R_ROOT;
			scc_pkg::ST_R_TOP:   state_d = sts.sp_zero ? scc_pkg::ST_R_ROOT : scc_pkg::ST_R_TOP2;
			scc_pkg::ST_R_TOP2:  state_d = scc_pkg::ST_R_VIS;
			scc_pkg::ST_R_VIS: begin
				if (sts.col_white && sts.list_ne) state_d = scc_pkg::ST_R_EDGE;
				else state_d = scc_pkg::ST_R_TOP;
			end
			scc_pkg::ST_R_EDGE:  state_d = scc_pkg::ST_R_EDGE2;
			scc_pkg::ST_R_EDGE2: state_d = scc_pkg::ST_R_EDGE3;
			scc_pkg::ST_R_EDGE3: state_d = sts.at_tail ? scc_pkg::ST_R_TOP : scc_pkg::ST_R_EDGE;
			scc_pkg::ST_DONE:    state_d = scc_pkg::ST_CLR;
			default:             state_d = scc_pkg::ST_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scc_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_done_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scc_pkg::ST_DONE) |=> (state_q == scc_pkg::ST_CLR))
		else $error("result not followed by store clear");
	a_edge_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scc_pkg::ST_EDGE) |=> !busy)
		else $error("edge load held the block busy too long");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.accept)
		else $error("accept while busy");
`endif
endmodule
`default_nettype wire

@@ src/scc_datapath.sv @@
`default_nettype none
module scc_datapath #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF,
	parameter int MAX_EDGES = scc_pkg::MAX_EDGES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire scc_pkg::in_t  item,
	input  wire logic          cfg_we,
	input  wire logic [10:0]   cfg_data,
	input  wire scc_pkg::cmd_t cmd,
	output scc_pkg::sts_t      sts,
	output scc_pkg::out_t      result,
	output logic               result_valid
);
	localparam int NAW   = $clog2(MAX_NODES + 1);
	localparam int FAW   = $clog2(MAX_NODES);
	localparam int SW    = $clog2(MAX_NODES + 2);
	localparam int RW    = $clog2(MAX_NODES + 2);
	localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int ECW   = $clog2(MAX_EDGES + 1);
	localparam int STAW  = $clog2(MAX_EDGES + 1);
	localparam int SPW   = $clog2(MAX_EDGES + 2);
	localparam int LW    = 1 + 2 * EAW;

	logic [10:0]    node_count_q;
	logic [ECW-1:0] edge_cnt_q;
	logic           drop_q;
	logic [NAW-1:0] node_q, u_q, sw_q, fc_q, k_q;
	logic [EAW-1:0] e_q, tail_q, nxt_q;
	logic [SW-1:0]  s_q;
	logic [SPW-1:0] sp_q;
	logic [RW-1:0]  jumps_q, best_q;
	logic [NAW-1:0] n_eff;

	// memories
	logic           col_we;  logic [NAW-1:0] col_wa, col_ra; logic [1:0] col_wd, col_rd;
	logic           fl_we;   logic [NAW-1:0] fl_wa, fl_ra;   logic [LW-1:0] fl_wd, fl_rd;
	logic           rl_we;   logic [NAW-1:0] rl_wa, rl_ra;   logic [LW-1:0] rl_wd, rl_rd;
	logic           ef_we;   logic [NAW-1:0] ef_wd, ef_rd, et_rd;
	logic [EAW-1:0] e_ra;
	logic           fn_we, rn_we; logic [EAW-1:0] fn_wa, rn_wa, fn_rd, rn_rd;
	logic           st_we;   logic [STAW-1:0] st_wa, st_ra; logic [NAW-1:0] st_wd, st_rd;
	logic           rc_we;   logic [NAW-1:0] rc_wa, rc_ra;  logic [RW-1:0] rc_wd, rc_rd;
	logic           fo_we;   logic [FAW-1:0] fo_wa, fo_ra;  logic [NAW-1:0] fo_rd;

	logic [NAW-1:0] in_src, in_dst;
	logic           can_push;
	scc_pkg::color_t col;
	logic [LW-1:0]  list_cur;

	assign n_eff  = (32'(node_count_q) > 32'(MAX_NODES)) ? NAW'(MAX_NODES) : NAW'(node_count_q);
	assign in_src = NAW'(item.src_node);
	assign in_dst = NAW'(item.dst_node);
	assign col    = scc_pkg::color_t'(col_rd);
	assign can_push = 32'(sp_q) <= 32'(MAX_EDGES);
	assign list_cur = (cmd.step == scc_pkg::ST_F_VIS) ? fl_rd : rl_rd;

	assign sts.is_start   = (item.cmd == scc_pkg::CMD_START);
	assign sts.edge_bad   = (item.src_node == 11'd0) || (item.dst_node == 11'd0)
		|| (32'(item.src_node) > 32'(n_eff)) || (32'(item.dst_node) > 32'(n_eff))
		|| (32'(edge_cnt_q) >= 32'(MAX_EDGES));
	assign sts.root_over  = 32'(s_q) > 32'(n_eff);
	assign sts.sp_zero    = (sp_q == '0);
	assign sts.col_white  = (col == scc_pkg::C_WHITE);
	assign sts.col_grey   = (col == scc_pkg::C_GREY);
	assign sts.list_ne    = list_cur[LW-1];
	assign sts.at_tail    = (e_q == tail_q);
	assign sts.k_zero     = (k_q == '0);
	assign sts.sweep_last = (sw_q == NAW'(MAX_NODES));

	assign result.longest_chain = 11'(best_q);
	assign result.dropped_edges = drop_q;
	assign result_valid         = (cmd.step == scc_pkg::ST_DONE);

	always_comb begin
		col_we = 1'b0; col_wa = node_q; col_wd = scc_pkg::C_WHITE; col_ra = NAW'(s_q);
		fl_we = 1'b0; fl_wa = node_q; fl_wd = '0; fl_ra = in_src;
		rl_we = 1'b0; rl_wa = u_q; rl_wd = '0; rl_ra = in_dst;
		ef_we = 1'b0; ef_wd = in_src; e_ra = e_q;
		fn_we = 1'b0; fn_wa = fl_rd[EAW-1:0];
		rn_we = 1'b0; rn_wa = rl_rd[EAW-1:0];
		st_we = 1'b0; st_wa = STAW'(sp_q); st_wd = node_q; st_ra = STAW'(sp_q - 1'b1);
		rc_we = 1'b0; rc_wa = node_q; rc_wd = RW'(jumps_q + 1'b1); rc_ra = ef_rd;
		fo_we = 1'b0; fo_wa = FAW'(fc_q); fo_ra = FAW'(k_q - 1'b1);
		case (cmd.step)
			scc_pkg::ST_CLR, scc_pkg::ST_R_CLR: begin
				col_we = 1'b1; col_wa = sw_q;
				if (cmd.step == scc_pkg::ST_CLR) begin
					fl_we = 1'b1; fl_wa = sw_q;
					rl_we = 1'b1; rl_wa = sw_q;
					rc_we = 1'b1; rc_wa = sw_q; rc_wd = '0;
				end
			end
			scc_pkg::ST_IDLE: begin
				ef_we = cmd.accept && !sts.is_start && !sts.edge_bad;
			end
			scc_pkg::ST_EDGE: begin
				// append the new edge to both lists
				fl_we = 1'b1;
				fl_wd = {1'b1, fl_rd[LW-1] ? fl_rd[2*EAW-1:EAW] : EAW'(edge_cnt_q),
					EAW'(edge_cnt_q)};
				rl_we = 1'b1;
				rl_wd = {1'b1, rl_rd[LW-1] ? rl_rd[2*EAW-1:EAW] : EAW'(edge_cnt_q),
					EAW'(edge_cnt_q)};
				fn_we = fl_rd[LW-1];
				rn_we = rl_rd[LW-1];
			end
			scc_pkg::ST_F_ROOT2: begin
				st_we = sts.col_white; st_wa = '0; st_wd = NAW'(s_q);
			end
			scc_pkg::ST_F_TOP2, scc_pkg::ST_R_TOP2: begin
				col_ra = st_rd; fl_ra = st_rd; rl_ra = st_rd;
			end
			scc_pkg::ST_F_VIS: begin
				col_we = sts.col_white || sts.col_grey;
				col_wd = sts.col_white ? scc_pkg::C_GREY : scc_pkg::C_BLACK;
				fo_we  = sts.col_grey && (32'(fc_q) < 32'(MAX_NODES));
			end
			scc_pkg::ST_F_EDGE2: begin
				st_we = can_push; st_wd = et_rd;
			end
			scc_pkg::ST_R_ROOT2: begin
				col_ra = fo_rd;
			end
			scc_pkg::ST_R_ROOT3: begin
				st_we = sts.col_white; st_wa = '0;
			end
			scc_pkg::ST_R_VIS: begin
				col_we = sts.col_grey || (sts.col_white && !sts.list_ne);
				col_wd = sts.col_grey ? scc_pkg::C_BLACK : scc_pkg::C_GREY;
				rc_we  = sts.col_grey;
			end
			scc_pkg::ST_R_EDGE2: begin
				col_ra = ef_rd;
			end
			scc_pkg::ST_R_EDGE3: begin
				st_we = sts.col_white && can_push; st_wd = u_q;
				col_we = sts.at_tail; col_wd = scc_pkg::C_GREY;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= 11'd1;
			edge_cnt_q   <= '0;
			drop_q       <= 1'b0;
			sw_q         <= '0;
			sp_q         <= '0;
			fc_q         <= '0;
			k_q          <= '0;
			s_q          <= '0;
		end else begin
			if (cfg_we) node_count_q <= cfg_data;
			case (cmd.step)
				scc_pkg::ST_CLR, scc_pkg::ST_R_CLR: begin
					sw_q <= sts.sweep_last ? '0 : sw_q + 1'b1;
					if (cmd.step == scc_pkg::ST_R_CLR) begin
						k_q <= fc_q; best_q <= '0;
					end
				end
				scc_pkg::ST_IDLE: begin
					if (cmd.accept) begin
						node_q <= in_src; u_q <= in_dst;
						if (sts.is_start) begin
							s_q <= SW'(1); fc_q <= '0;
						end else if (sts.edge_bad) begin
							drop_q <= 1'b1;
						end
					end
				end
				scc_pkg::ST_EDGE: edge_cnt_q <= edge_cnt_q + 1'b1;
				scc_pkg::ST_F_ROOT2: begin
					if (sts.col_white) sp_q <= SPW'(1);
					else s_q <= s_q + 1'b1;
				end
				scc_pkg::ST_F_TOP, scc_pkg::ST_R_TOP: begin
					if (sts.sp_zero && cmd.step == scc_pkg::ST_F_TOP) s_q <= s_q + 1'b1;
				end
				scc_pkg::ST_F_TOP2, scc_pkg::ST_R_TOP2: node_q <= st_rd;
				scc_pkg::ST_F_VIS, scc_pkg::ST_R_VIS: begin
					if (sts.col_white) begin
						e_q    <= list_cur[2*EAW-1:EAW];
						tail_q <= list_cur[EAW-1:0];
					end else begin
						sp_q <= sp_q - 1'b1;
					end
					if (cmd.step == scc_pkg::ST_F_VIS && sts.col_grey) begin
						if (32'(fc_q) < 32'(MAX_NODES)) fc_q <= fc_q + 1'b1;
					end
					if (cmd.step == scc_pkg::ST_R_VIS && sts.col_grey) begin
						if (jumps_q > best_q) best_q <= jumps_q;
					end
				end
				scc_pkg::ST_F_EDGE2: begin
					if (can_push) sp_q <= sp_q + 1'b1;
					e_q <= fn_rd;
				end
				scc_pkg::ST_R_ROOT2: node_q <= fo_rd;
				scc_pkg::ST_R_ROOT3: begin
					k_q <= k_q - 1'b1;
					if (sts.col_white) begin
						sp_q <= SPW'(1); jumps_q <= '0;
					end
				end
				scc_pkg::ST_R_EDGE2: begin
					u_q <= ef_rd; nxt_q <= rn_rd;
				end
				scc_pkg::ST_R_EDGE3: begin
					if (sts.col_white && can_push) sp_q <= sp_q + 1'b1;
					// stored reach is offset by one, so "reach >= jumps" is "rc > jumps"
					if (rc_rd > jumps_q) jumps_q <= rc_rd;
					e_q <= nxt_q;
				end
				scc_pkg::ST_DONE: begin
					edge_cnt_q <= '0; drop_q <= 1'b0; sw_q <= '0;
				end
				default: ;
			endcase
		end
	end

	scc_ram #(.W(2), .D(MAX_NODES + 1)) u_color (
		.clk(clk), .we(col_we), .waddr(col_wa), .wdata(col_wd), .raddr(col_ra), .rdata(col_rd));
	scc_ram #(.W(LW), .D(MAX_NODES + 1)) u_fwd_list (
		.clk(clk), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd), .raddr(fl_ra), .rdata(fl_rd));
	scc_ram #(.W(LW), .D(MAX_NODES + 1)) u_rev_list (
		.clk(clk), .we(rl_we), .waddr(rl_wa), .wdata(rl_wd), .raddr(rl_ra), .rdata(rl_rd));
	scc_ram #(.W(NAW), .D(MAX_EDGES)) u_edge_from (
		.clk(clk), .we(ef_we), .waddr(EAW'(edge_cnt_q)), .wdata(ef_wd), .raddr(e_ra),
		.rdata(ef_rd));
	scc_ram #(.W(NAW), .D(MAX_EDGES)) u_edge_to (
		.clk(clk), .we(ef_we), .waddr(EAW'(edge_cnt_q)), .wdata(in_dst), .raddr(e_ra),
		.rdata(et_rd));
	scc_ram #(.W(EAW), .D(MAX_EDGES)) u_fwd_next (
		.clk(clk), .we(fn_we), .waddr(fn_wa), .wdata(EAW'(edge_cnt_q)), .raddr(e_ra),
		.rdata(fn_rd));
	scc_ram #(.W(EAW), .D(MAX_EDGES)) u_rev_next (
		.clk(clk), .we(rn_we), .waddr(rn_wa), .wdata(EAW'(edge_cnt_q)), .raddr(e_ra),
		.rdata(rn_rd));
	scc_ram #(.W(NAW), .D(MAX_EDGES + 1)) u_stack (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
	scc_ram #(.W(RW), .D(MAX_NODES + 1)) u_reach (
		.clk(clk), .we(rc_we), .waddr(rc_wa), .wdata(rc_wd), .raddr(rc_ra), .rdata(rc_rd));
	scc_ram #(.W(NAW), .D(MAX_NODES)) u_finish (
		.clk(clk), .we(fo_we), .waddr(fo_wa), .wdata(node_q), .raddr(fo_ra), .rdata(fo_rd));

`ifndef SYNTHESIS
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(sp_q) <= 32'(MAX_EDGES) + 1)
		else $error("work stack overflow");
	a_fc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fc_q) <= 32'(MAX_NODES))
		else $error("finish count overflow");
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(edge_cnt_q) <= 32'(MAX_EDGES))
		else $error("edge count overflow");
`endif
endmodule
`default_nettype wire

@@ bench/scc_longest_chain_core_test.sv @@
`timescale 1ns / 1ps
module scc_longest_chain_core_test;

	localparam int NODES = scc_pkg::MAX_NODES_DEF;
	localparam int EDGES = scc_pkg::MAX_EDGES_DEF;
	localparam int CYCLE_LIMIT = 20000000;
	localparam int TAIL_CYCLES = 64;

	// Scoreboard: predicts the longest jump chain of each loaded graph
	class chain_board;
		int unsigned     node_cnt;
		int              edge_n;
		int              e_from[EDGES], e_to[EDGES], f_next[EDGES], r_next[EDGES];
		int              f_head[NODES + 1], f_tail[NODES + 1], f_len[NODES + 1];
		int              r_head[NODES + 1], r_tail[NODES + 1], r_len[NODES + 1];
		scc_pkg::color_t color[NODES + 1];
		int              reach[NODES + 1];
		int              fin[NODES];
		int              fin_n;
		int              stk[EDGES + 1];
		int              sp;
		bit              drop;
		scc_pkg::out_t   chain_q[$];
		int              errors;

		function void clear_graph();
			edge_n = 0;
			fin_n = 0;
			sp = 0;
			drop = 0;
			for (int i = 0; i <= NODES; i++) begin
				f_len[i] = 0; r_len[i] = 0; f_head[i] = 0; r_head[i] = 0;
				f_tail[i] = 0; r_tail[i] = 0;
				color[i] = scc_pkg::C_WHITE;
				reach[i] = -1;
			end
		endfunction

		function void init();
			node_cnt = 1;
			errors = 0;
			clear_graph();
		endfunction

		function int eff_nodes();
			return node_cnt > NODES ? NODES : int'(node_cnt);
		endfunction

		function void push(int v);
			if (sp <= EDGES) begin
				stk[sp] = v;
				sp++;
			end
		endfunction

		function void add_edge(int u, int v);
			int n;
			int e;
			n = eff_nodes();
			if (u == 0 || v == 0 || u > n || v > n || edge_n >= EDGES) begin
				drop = 1;
				return;
			end
			e = edge_n;
			edge_n++;
			e_from[e] = u;
			e_to[e] = v;
			if (f_len[u] == 0) f_head[u] = e; else f_next[f_tail[u]] = e;
			f_tail[u] = e;
			f_len[u]++;
			if (r_len[v] == 0) r_head[v] = e; else r_next[r_tail[v]] = e;
			r_tail[v] = e;
			r_len[v]++;
		endfunction

		function void walk_forward(int n);
			int e, v;
			fin_n = 0;
			for (int s = 1; s <= n; s++) begin
				if (color[s] != scc_pkg::C_WHITE) continue;
				sp = 0;
				push(s);
				while (sp > 0) begin
					v = stk[sp - 1];
					if (color[v] == scc_pkg::C_WHITE) begin
						e = f_head[v];
						for (int k = 0; k < f_len[v]; k++) begin
							push(e_to[e]);
							e = f_next[e];
						end
						color[v] = scc_pkg::C_GREY;
					end else if (color[v] == scc_pkg::C_GREY) begin
						// a grey node back on top finishes here
						color[v] = scc_pkg::C_BLACK;
						sp--;
						if (fin_n < NODES) begin
							fin[fin_n] = v;
							fin_n++;
						end
					end else begin
						sp--;
					end
				end
			end
		endfunction

		function int walk_reverse();
			int e, v, u, root, jumps, best;
			best = 0;
			for (int i = 0; i <= NODES; i++) color[i] = scc_pkg::C_WHITE;
			for (int k = fin_n; k > 0; k--) begin
				root = fin[k - 1];
				if (color[root] != scc_pkg::C_WHITE) continue;
				sp = 0;
				push(root);
				jumps = 0;
				while (sp > 0) begin
					v = stk[sp - 1];
					if (color[v] == scc_pkg::C_WHITE) begin
						e = r_head[v];
						for (int j = 0; j < r_len[v]; j++) begin
							u = e_from[e];
							if (color[u] == scc_pkg::C_WHITE) push(u);
							if (reach[u] >= jumps) jumps = reach[u] + 1;
							e = r_next[e];
						end
						color[v] = scc_pkg::C_GREY;
					end else if (color[v] == scc_pkg::C_GREY) begin
						color[v] = scc_pkg::C_BLACK;
						reach[v] = jumps;
						if (jumps > best) best = jumps;
						sp--;
					end else begin
						sp--;
					end
				end
			end
			return best;
		endfunction

		function void note_transfer(scc_pkg::in_t it);
			scc_pkg::out_t exp_r;
			int best;
			if (it.cmd == scc_pkg::CMD_ADD) begin
				add_edge(int'(it.src_node), int'(it.dst_node));
				return;
			end
			for (int i = 0; i <= NODES; i++) begin
				color[i] = scc_pkg::C_WHITE;
				reach[i] = -1;
			end
			walk_forward(eff_nodes());
			best = walk_reverse();
			exp_r.longest_chain = best[10:0];
			exp_r.dropped_edges = drop;
			chain_q = {chain_q, exp_r};
			clear_graph();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_result(scc_pkg::out_t got);
			scc_pkg::out_t exp_r;
			if (chain_q.size() == 0) begin
				report($sformatf("unexpected result chain=%0d dropped=%0b",
					got.longest_chain, got.dropped_edges));
				return;
			end
			exp_r = chain_q.pop_front();
			if (got.longest_chain !== exp_r.longest_chain)
				report($sformatf("longest_chain got %0d want %0d",
					got.longest_chain, exp_r.longest_chain));
			if (got.dropped_edges !== exp_r.dropped_edges)
				report($sformatf("dropped_edges got %0b want %0b",
					got.dropped_edges, exp_r.dropped_edges));
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	scc_pkg::in_t  item;
	scc_pkg::out_t result;
	logic          result_valid;
	logic          cfg_we;
	logic [10:0]   cfg_data;

	chain_board sb;
	int         cycles;
	int         sent;
	bit         calm;

	scc_longest_chain_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("scc_longest_chain_core regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) sb.check_result(result);
	end

	function int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (calm || r < 11) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Present an item from a falling edge and hold it until the transfer.
	task send(logic c, logic [10:0] s, logic [10:0] d);
		scc_pkg::in_t it;
		bit  acc;
		int  g;
		it.cmd = c;
		it.src_node = s;
		it.dst_node = d;
		start <= 1'b1;
		item <= it;
		forever begin
			#1;
			acc = !busy;
			@(posedge clk);
			if (acc) break;
			@(negedge clk);
		end
		sb.note_transfer(it);
		sent++;
		@(negedge clk);
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			item <= scc_pkg::in_t'($bits(scc_pkg::in_t)'($urandom()));
			repeat (g) @(negedge clk);
		end
	endtask

	task drain();
		start <= 1'b0;
		while (sb.chain_q.size() != 0 || busy) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task write_count(logic [10:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		sb.node_cnt = v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 11'($urandom());
	endtask

	task add(int s, int d);
		send(scc_pkg::CMD_ADD, 11'(s), 11'(d));
	endtask

	task run_walk();
		send(scc_pkg::CMD_START, 11'($urandom()), 11'($urandom()));
	endtask

	function logic [10:0] pick_count();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return 11'd0;
		if (r == 1) return 11'd1024;
		if (r == 2) return 11'd2047;
		if (r == 3) return 11'($urandom_range(0, 2047));
		if (r < 10) return 11'($urandom_range(11, 40));
		return 11'($urandom_range(1, 10));
	endfunction

	task rand_edge();
		int n, r;
		n = sb.eff_nodes();
		r = $urandom_range(0, 9);
		if (n > 0 && r < 9) begin
			add($urandom_range(1, n), $urandom_range(1, n));
		end else begin
			case ($urandom_range(0, 2))
				0: add(0, $urandom_range(0, 2047));
				1: add($urandom_range(1, 2047), n + $urandom_range(1, 2047 - n));
				default: add($urandom_range(0, 2047), $urandom_range(0, 2047));
			endcase
		end
	endtask

	initial begin
		int n_edges, n_now;
		sb = new;
		sb.init();
		cycles = 0;
		sent = 0;
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty graph, zero nodes, widest endpoints, lowered count
		run_walk();
		write_count(11'd0);
		run_walk();
		add(1, 1);
		run_walk();
		write_count(11'd1024);
		add(1, 1024);
		add(1024, 1);
		add(0, 5);
		add(2047, 3);
		run_walk();
		write_count(11'd2047);
		add(1024, 1024);
		add(1025, 1);
		add(1023, 1024);
		run_walk();
		write_count(11'd6);
		add(1, 2);
		add(2, 3);
		add(3, 4);
		add(4, 5);
		add(5, 6);
		add(5, 2);
		write_count(11'd3);
		run_walk();

		while (sent < 1150) begin
			if ($urandom_range(0, 2) == 0) write_count(pick_count());
			calm = ($urandom_range(0, 5) == 0);
			n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60)
				: $urandom_range(0, 24);
			for (int i = 0; i < n_edges; i++) rand_edge();
			if ($urandom_range(0, 9) == 0) begin
				n_now = sb.eff_nodes();
				write_count(11'($urandom_range(0, n_now > 1 ? n_now - 1 : 1)));
			end
			run_walk();
		end

		start <= 1'b0;
		while (sb.chain_q.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("scc_longest_chain_core regression: pass");
		else
			$display("scc_longest_chain_core regression: fail");
		$finish;
	end
endmodule
